// ===== hw/rtl/rds_pkg.sv =====
// Shared constants, register codes and control types of the diffusion stencil step.
// No dependencies; every other file of the block but rds_ram uses it.
package rds_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int INDEX_BITS     = 10;
    localparam int INDEX_LIMIT    = 1024;
    localparam int SIZE_BITS      = 11;
    localparam int GAIN_BITS      = 16;
    localparam int FRAC_BITS      = 16;
    localparam int CENTER_SHIFT   = 2;    // center weight of four
    localparam int MAX_RESULTS    = 4;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [SIZE_BITS-1:0] MIN_SIZE = 11'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT    = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIFFUSION_GAIN = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_GAIN     = 8'd3;

    localparam logic [SIZE_BITS-1:0] GRID_WIDTH_RST     = 11'd64;
    localparam logic [SIZE_BITS-1:0] GRID_HEIGHT_RST    = 11'd64;
    localparam logic [GAIN_BITS-1:0] DIFFUSION_GAIN_RST = 16'd6554;
    localparam logic [GAIN_BITS-1:0] DECAY_GAIN_RST     = 16'd66;

    // Position and write plan of one cell as it moves down the pipeline
    typedef struct packed {
        logic [INDEX_BITS-1:0] row;       // row being updated (input row - 1)
        logic [INDEX_BITS-1:0] col;
        logic [INDEX_BITS-1:0] row_max;   // grid height - 1
        logic [INDEX_BITS-1:0] col_max;   // grid width - 1
        logic                  interior;
        logic                  is_edge;   // last column: emits the edge copies
        logic                  top;
        logic                  bottom;
        logic                  first_col;
        logic                  last_col;
        logic                  col_zero;
        logic                  right_ok;
    } rds_ctrl_t;

endpackage

// ===== hw/rtl/rds_ifs.sv =====
// Valid/ready channel interfaces: cell stream in, cell writes out, register writes.
// Depends on rds_pkg for default widths.
interface rds_cell_if #(parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic                         grid_start;

    modport source (output valid, cell_value, grid_start, input ready);
    modport sink   (input valid, cell_value, grid_start, output ready);
endinterface

interface rds_write_if #(parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF) ();
    logic                                 valid;
    logic                                 ready;
    logic [rds_pkg::INDEX_BITS-1:0]       row_index;
    logic [rds_pkg::INDEX_BITS-1:0]       column_index;
    logic signed [VALUE_BITS-1:0]         new_value;
    logic                                 last_of_run;

    modport source (output valid, row_index, column_index, new_value, last_of_run, input ready);
    modport sink   (input valid, row_index, column_index, new_value, last_of_run, output ready);
endinterface

interface rds_cfg_if ();
    logic                                valid;
    logic                                ready;
    logic [rds_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [rds_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/reaction_diffusion_stencil_step.sv =====
// Top level of the streaming five-point diffusion-decay step: registers, line buffers.
// Depends on rds_pkg, rds_ifs, rds_ram, rds_front, rds_datapath, rds_emit.
//
//   channel | dir | payload                                             | accepted when
//   cells   | in  | cell_value, grid_start                              | valid & ready
//   writes  | out | row_index, column_index, new_value, last_of_run     | valid & ready
//   cfg     | in  | index, data                                         | valid & ready
//
// One cell per cycle unless stalled; a cell holds the input until its last write is loaded.
// The first write of a cell passes the input register, Laplacian, gain products,
// write plan, then the output register.
// Two line buffers, one read per cycle each, set the one-cell-per-cycle rate.
// Reset clears counters, window, pipeline valids and registers; line buffers are not cleared.
// cfg is always ready; the cells side stalls while a cell's later writes wait their turn,
// and while writes holds off with the output register full.
module reaction_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = rds_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rds_cfg_if.sink     cfg,
    rds_cell_if.sink    cells,
    rds_write_if.source writes
);
    import rds_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int VB = VALUE_BITS;

    logic [SIZE_BITS-1:0] grid_width_reg, grid_height_reg;
    logic [GAIN_BITS-1:0] diffusion_gain_reg, decay_gain_reg;

    logic adv, accept;
    logic [AW-1:0] addr_here, addr_right, wr_addr;
    logic s1_valid, wr_en, res_valid;
    rds_ctrl_t s1_ctrl, res_ctrl;
    logic signed [VB-1:0] s1_value, res_value;
    logic [2*VB-1:0] here_ram, here_q, wr_here, byp_here_reg;
    logic [VB-1:0]   right_ram, right_q, wr_right, byp_right_reg;
    logic here_hit_reg, right_hit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= GRID_WIDTH_RST;
            grid_height_reg    <= GRID_HEIGHT_RST;
            diffusion_gain_reg <= DIFFUSION_GAIN_RST;
            decay_gain_reg     <= DECAY_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GRID_WIDTH:     grid_width_reg     <= cfg.data[SIZE_BITS-1:0];
                REG_GRID_HEIGHT:    grid_height_reg    <= cfg.data[SIZE_BITS-1:0];
                REG_DIFFUSION_GAIN: diffusion_gain_reg <= cfg.data[GAIN_BITS-1:0];
                REG_DECAY_GAIN:     decay_gain_reg     <= cfg.data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cells.ready = adv;
    assign accept      = cells.valid && adv;

    rds_front #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .accept      (accept),
        .cell_value  (cells.cell_value),
        .grid_start  (cells.grid_start),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .addr_here   (addr_here),
        .addr_right  (addr_right),
        .s1_valid    (s1_valid),
        .s1_ctrl     (s1_ctrl),
        .s1_value    (s1_value)
    );

    // {upper, middle} at the cell's column
    rds_ram #(.WIDTH(2*VB), .DEPTH(MAX_WIDTH)) u_ram_here (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_here),
        .re    (adv),
        .raddr (addr_here),
        .rdata (here_ram)
    );

    // middle line copy read one column ahead for the window
    rds_ram #(.WIDTH(VB), .DEPTH(MAX_WIDTH)) u_ram_right (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_right),
        .re    (adv),
        .raddr (addr_right),
        .rdata (right_ram)
    );

    // a read of the column being written in the same cycle takes the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            here_hit_reg  <= 1'b0;
            right_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            here_hit_reg  <= wr_en && (wr_addr == addr_here);
            right_hit_reg <= wr_en && (wr_addr == addr_right);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp_here_reg  <= wr_here;
            byp_right_reg <= wr_right;
        end
    end

    assign here_q  = here_hit_reg ? byp_here_reg : here_ram;
    assign right_q = right_hit_reg ? byp_right_reg : right_ram;

    rds_datapath #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .s1_valid       (s1_valid),
        .s1_ctrl        (s1_ctrl),
        .s1_value       (s1_value),
        .here_q         (here_q),
        .right_q        (right_q),
        .diffusion_gain (diffusion_gain_reg),
        .decay_gain     (decay_gain_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_here        (wr_here),
        .wr_right       (wr_right),
        .res_valid      (res_valid),
        .res_ctrl       (res_ctrl),
        .res_value      (res_value)
    );

    rds_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ctrl  (res_ctrl),
        .res_value (res_value),
        .out_ready (writes.ready),
        .adv       (adv),
        .out_valid (writes.valid),
        .out_row   (writes.row_index),
        .out_col   (writes.column_index),
        .out_value (writes.new_value),
        .out_last  (writes.last_of_run)
    );

`ifndef ASSERT_OFF
    // input stalls only behind a write that is, or becomes, pending
    a_stall_has_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cells.ready |=> writes.valid)
        else $error("input stalled with no write pending");

    // the writes of one cell leave back to back
    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (writes.valid && writes.ready && !writes.last_of_run) |=> writes.valid)
        else $error("gap inside a run of writes");

    // line buffer write happens only while the pipeline moves
    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (adv && s1_valid))
        else $error("line buffer written while stalled");
`endif

endmodule

// ===== hw/rtl/rds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rds_front.sv =====
// Raster position tracking, size clamping and the input register stage.
// Depends on rds_pkg; drives the line buffer read addresses.
module rds_front #(
    parameter int MAX_WIDTH  = rds_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            accept,
    input  logic signed [VALUE_BITS-1:0]    cell_value,
    input  logic                            grid_start,
    input  logic [rds_pkg::SIZE_BITS-1:0]   grid_width,
    input  logic [rds_pkg::SIZE_BITS-1:0]   grid_height,
    output logic [AW-1:0]                   addr_here,
    output logic [AW-1:0]                   addr_right,
    output logic                            s1_valid,
    output rds_pkg::rds_ctrl_t              s1_ctrl,
    output logic signed [VALUE_BITS-1:0]    s1_value
);
    import rds_pkg::*;

    localparam int LIM_W = (MAX_WIDTH < INDEX_LIMIT) ? MAX_WIDTH : INDEX_LIMIT;

    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] lim
    );
        logic [SIZE_BITS-1:0] res;
        begin
            res = v;
            if (v < MIN_SIZE)
            begin
                res = MIN_SIZE;
            end
            else if (v > lim)
            begin
                res = lim;
            end
            return res;
        end
    endfunction

    logic [INDEX_BITS-1:0] row_cnt_reg, row_cnt_next;
    logic [INDEX_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic                  s1_valid_reg;
    rds_ctrl_t             s1_ctrl_reg, ctrl_next;
    logic signed [VALUE_BITS-1:0] s1_value_reg;

    logic [SIZE_BITS-1:0]  w, h, w_m1, w_m2, h_m1;
    logic [INDEX_BITS-1:0] row0, col0, rr, cc;
    logic [SIZE_BITS-1:0]  r1, c_inc, r_inc;
    logic                  wrap_col;

    always_comb
    begin
        w    = clamp_size(grid_width, SIZE_BITS'(LIM_W));
        h    = clamp_size(grid_height, SIZE_BITS'(INDEX_LIMIT));
        w_m1 = w - 11'd1;
        w_m2 = w - 11'd2;
        h_m1 = h - 11'd1;

        row0 = grid_start ? '0 : row_cnt_reg;
        col0 = grid_start ? '0 : col_cnt_reg;

        // a column past a shrunk width starts the next row
        wrap_col = ({1'b0, col0} >= w);
        r1 = wrap_col ? ({1'b0, row0} + 11'd1) : {1'b0, row0};
        rr = (r1 >= h) ? '0 : r1[INDEX_BITS-1:0];
        cc = wrap_col ? '0 : col0;

        c_inc = {1'b0, cc} + 11'd1;
        r_inc = {1'b0, rr} + 11'd1;

        if (c_inc >= w)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r_inc >= h) ? '0 : r_inc[INDEX_BITS-1:0];
        end
        else
        begin
            col_cnt_next = c_inc[INDEX_BITS-1:0];
            row_cnt_next = rr;
        end

        ctrl_next.row       = rr - 10'd1;
        ctrl_next.col       = cc;
        ctrl_next.row_max   = h_m1[INDEX_BITS-1:0];
        ctrl_next.col_max   = w_m1[INDEX_BITS-1:0];
        ctrl_next.interior  = (rr >= 10'd2) && (cc != 10'd0) && ({1'b0, cc} <= w_m2);
        ctrl_next.is_edge   = (rr >= 10'd2) && ({1'b0, cc} == w_m1);
        ctrl_next.top       = (rr == 10'd2);
        ctrl_next.bottom    = ({1'b0, rr} == h_m1);
        ctrl_next.first_col = (cc == 10'd1);
        ctrl_next.last_col  = ({1'b0, cc} == w_m2);
        ctrl_next.col_zero  = (cc == 10'd0);
        ctrl_next.right_ok  = (c_inc < w);
    end

    assign addr_here  = AW'(cc);
    assign addr_right = AW'(c_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctrl_reg  <= ctrl_next;
            s1_value_reg <= cell_value;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;
    assign s1_value = s1_value_reg;

endmodule

// ===== hw/rtl/rds_datapath.sv =====
// Middle-row window, Laplacian, gain products, rounding and saturation.
// Depends on rds_pkg; fed by rds_front and the line buffers, feeds rds_emit.
module rds_datapath #(
    parameter int MAX_WIDTH  = rds_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            s1_valid,
    input  rds_pkg::rds_ctrl_t              s1_ctrl,
    input  logic signed [VALUE_BITS-1:0]    s1_value,
    input  logic [2*VALUE_BITS-1:0]         here_q,
    input  logic [VALUE_BITS-1:0]           right_q,
    input  logic [rds_pkg::GAIN_BITS-1:0]   diffusion_gain,
    input  logic [rds_pkg::GAIN_BITS-1:0]   decay_gain,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output logic [2*VALUE_BITS-1:0]         wr_here,
    output logic [VALUE_BITS-1:0]           wr_right,
    output logic                            res_valid,
    output rds_pkg::rds_ctrl_t              res_ctrl,
    output logic signed [VALUE_BITS-1:0]    res_value
);
    import rds_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int LW = VB + 3;              // five-point sum headroom
    localparam int PW = GAIN_BITS + 1 + LW;
    localparam int KW = GAIN_BITS + 1 + VB;
    localparam int SW = PW + 1;
    localparam int TW = SW + 1;

    localparam logic signed [SW-1:0] HALF =
        {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    logic signed [VB-1:0] win_reg [3];
    logic signed [VB-1:0] win_next [3];
    logic signed [VB-1:0] up, old_mid, nxt;
    logic signed [LW-1:0] lap_next;

    logic                 s2_valid_reg;
    rds_ctrl_t            s2_ctrl_reg;
    logic signed [LW-1:0] s2_lap_reg;
    logic signed [VB-1:0] s2_mid_reg;

    logic                 s3_valid_reg;
    rds_ctrl_t            s3_ctrl_reg;
    logic signed [PW-1:0] s3_pd_reg;
    logic signed [KW-1:0] s3_pk_reg;
    logic signed [VB-1:0] s3_mid_reg;

    logic signed [GAIN_BITS:0] dg_s, kg_s;
    logic signed [SW-1:0] sum, shifted;
    logic signed [TW-1:0] total;

    always_comb
    begin
        up      = $signed(here_q[2*VB-1:VB]);
        old_mid = $signed(here_q[VB-1:0]);
        nxt     = s1_ctrl.right_ok ? $signed(right_q) : '0;

        if (s1_ctrl.col_zero)
        begin
            win_next[0] = '0;
            win_next[1] = old_mid;
            win_next[2] = nxt;
        end
        else
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = nxt;
        end

        lap_next = LW'(up) + LW'(s1_value) + LW'(win_next[0]) + LW'(win_next[2])
                 - (LW'(win_next[1]) <<< CENTER_SHIFT);
    end

    // row r-1 moves to the upper line, the new cell to the middle line
    assign wr_en    = adv && s1_valid;
    assign wr_addr  = AW'(s1_ctrl.col);
    assign wr_here  = {old_mid, s1_value};
    assign wr_right = s1_value;

    assign dg_s = $signed({1'b0, diffusion_gain});
    assign kg_s = $signed({1'b0, decay_gain});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
            win_reg[2]   <= '0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_valid)
            begin
                win_reg[0] <= win_next[0];
                win_reg[1] <= win_next[1];
                win_reg[2] <= win_next[2];
            end
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctrl_reg <= s1_ctrl;
            s2_lap_reg  <= lap_next;
            s2_mid_reg  <= win_next[1];
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_pd_reg   <= PW'(dg_s * s2_lap_reg);
            s3_pk_reg   <= KW'(kg_s * s2_mid_reg);
            s3_mid_reg  <= s2_mid_reg;
        end
    end

    // round to nearest, ties up, then saturate
    always_comb
    begin
        sum     = SW'(s3_pd_reg) - SW'(s3_pk_reg) + HALF;
        shifted = sum >>> FRAC_BITS;
        total   = TW'(shifted) + TW'(s3_mid_reg);
        if (total > TW'(VMAX))
        begin
            res_value = VMAX;
        end
        else if (total < TW'(VMIN))
        begin
            res_value = VMIN;
        end
        else
        begin
            res_value = $signed(total[VB-1:0]);
        end
    end

    assign res_valid = s3_valid_reg;
    assign res_ctrl  = s3_ctrl_reg;

endmodule

// ===== hw/rtl/rds_emit.sv =====
// Write plan per cell (interior write plus border copies) and the output register.
// Depends on rds_pkg; produces the pipeline advance for all earlier stages.
module rds_emit #(
    parameter int VALUE_BITS = rds_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    input  rds_pkg::rds_ctrl_t                res_ctrl,
    input  logic signed [VALUE_BITS-1:0]      res_value,
    input  logic                              out_ready,
    output logic                              adv,
    output logic                              out_valid,
    output logic [rds_pkg::INDEX_BITS-1:0]    out_row,
    output logic [rds_pkg::INDEX_BITS-1:0]    out_col,
    output logic signed [VALUE_BITS-1:0]      out_value,
    output logic                              out_last
);
    import rds_pkg::*;

    localparam int NCAND = 6;

    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic                  use_b;   // right-edge copy value
        logic                  en;
    } slot_t;

    slot_t cand [NCAND];
    slot_t slot_next [MAX_RESULTS];
    slot_t slot_reg [MAX_RESULTS];
    logic [2:0] n_next, cnt_reg;
    logic [1:0] k_reg;
    logic signed [VALUE_BITS-1:0] a_reg, b_reg, row_first_reg, row_last_reg;
    logic s4_valid_reg, out_load, last_slot, s4_done;

    logic                         out_valid_reg, out_last_reg;
    logic [INDEX_BITS-1:0]        out_row_reg, out_col_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    slot_t                        cur;

    always_comb
    begin
        cand[0] = '{row: res_ctrl.row, col: (res_ctrl.is_edge ? '0 : res_ctrl.col),
                    use_b: 1'b0, en: (res_ctrl.interior || res_ctrl.is_edge)};
        if (res_ctrl.interior)
        begin
            cand[1] = '{row: '0, col: res_ctrl.col, use_b: 1'b0, en: res_ctrl.top};
            cand[2] = '{row: res_ctrl.row_max, col: res_ctrl.col, use_b: 1'b0,
                        en: res_ctrl.bottom};
        end
        else
        begin
            cand[1] = '{row: res_ctrl.row, col: res_ctrl.col_max, use_b: 1'b1,
                        en: res_ctrl.is_edge};
            cand[2] = '{row: '0, col: '0, use_b: 1'b0,
                        en: (res_ctrl.is_edge && res_ctrl.top)};
        end
        cand[3] = '{row: '0, col: res_ctrl.col_max, use_b: 1'b1,
                    en: (res_ctrl.is_edge && res_ctrl.top)};
        cand[4] = '{row: res_ctrl.row_max, col: '0, use_b: 1'b0,
                    en: (res_ctrl.is_edge && res_ctrl.bottom)};
        cand[5] = '{row: res_ctrl.row_max, col: res_ctrl.col_max, use_b: 1'b1,
                    en: (res_ctrl.is_edge && res_ctrl.bottom)};

        // pack enabled writes in order; a three-row grid keeps only four
        n_next = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_next[i] = '0;
        end
        for (int j = 0; j < NCAND; j++)
        begin
            if (cand[j].en && (n_next < 3'd4))
            begin
                slot_next[n_next[1:0]] = cand[j];
                n_next = n_next + 3'd1;
            end
        end
    end

    assign cur       = slot_reg[k_reg];
    assign last_slot = ({1'b0, k_reg} == (cnt_reg - 3'd1));
    assign out_load  = s4_valid_reg && (!out_valid_reg || out_ready);
    assign s4_done   = out_load && last_slot;
    assign adv       = !s4_valid_reg || s4_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            row_first_reg <= '0;
            row_last_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                s4_valid_reg <= res_valid && (n_next != 3'd0);
                k_reg        <= '0;
                if (res_valid && res_ctrl.interior && res_ctrl.first_col)
                begin
                    row_first_reg <= res_value;
                end
                if (res_valid && res_ctrl.interior && res_ctrl.last_col)
                begin
                    row_last_reg <= res_value;
                end
            end
            else if (out_load)
            begin
                k_reg <= k_reg + 2'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot_reg <= slot_next;
            cnt_reg  <= n_next;
            a_reg    <= res_ctrl.interior ? res_value : row_first_reg;
            b_reg    <= row_last_reg;
        end
        if (out_load)
        begin
            out_row_reg   <= cur.row;
            out_col_reg   <= cur.col;
            out_value_reg <= cur.use_b ? b_reg : a_reg;
            out_last_reg  <= last_slot;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== verif/rds_step_checker.sv =====
// Scoreboard for the diffusion stencil step: tracks the register and cell channels,
// predicts every cell write and compares it with the writes channel.
// Depends on rds_pkg and the channel interfaces in rds_ifs.
module rds_step_checker
    import rds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rds_cfg_if    cfg,
    rds_cell_if   cells,
    rds_write_if  writes,
    output int    failures,
    output int    awaited,
    output int    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int WIDTH_LIMIT = (MAX_WIDTH_DEF < INDEX_LIMIT) ? MAX_WIDTH_DEF : INDEX_LIMIT;

    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [VB-1:0]         value;
        logic                  last;
    } cell_write_t;

    cell_write_t due_writes[$];

    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic [GAIN_BITS-1:0] diff_gain, decay_gain;

    // two rows back and one row back, plus the sliding window on the row above the input
    logic signed [VB-1:0] older_row [MAX_WIDTH_DEF];
    logic signed [VB-1:0] newer_row [MAX_WIDTH_DEF];
    logic signed [VB-1:0] window [3];
    logic signed [VB-1:0] left_edge_val, right_edge_val;
    int unsigned          row_pos, col_pos;

    function automatic int unsigned clamp_dim(logic [SIZE_BITS-1:0] v, int unsigned limit);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // cell + round((dg * laplacian - kg * cell) / 2^16), ties up, then saturate
    function automatic logic signed [VB-1:0] relax(longint up, longint down, longint left,
                                                   longint mid, longint right);
        longint lap, acc, top_val, bot_val;
        top_val = (64'sd1 << (VB - 1)) - 1;
        bot_val = -top_val - 1;
        lap = up + down + left + right - (mid <<< CENTER_SHIFT);
        acc = mid + ((longint'(diff_gain) * lap - longint'(decay_gain) * mid
                      + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (acc > top_val)
            acc = top_val;
        else if (acc < bot_val)
            acc = bot_val;
        return acc[VB-1:0];
    endfunction

    function automatic cell_write_t plan_write(int unsigned r, int unsigned c, logic [VB-1:0] v);
        cell_write_t wr;
        wr.row   = r[INDEX_BITS-1:0];
        wr.col   = c[INDEX_BITS-1:0];
        wr.value = v;
        wr.last  = 1'b0;
        return wr;
    endfunction

    function automatic void stencil_update(logic signed [VB-1:0] value, logic start);
        cell_write_t          burst[$];
        int unsigned          w, h, r, c, i;
        logic signed [VB-1:0] above, old_mid, nv;
        w = clamp_dim(width_reg, WIDTH_LIMIT);
        h = clamp_dim(height_reg, INDEX_LIMIT);
        if (start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        // counters left past a shrunk size wrap to the next row / next grid
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;

        above   = older_row[c];
        old_mid = newer_row[c];
        if (c == 0)
        begin
            window[0] = '0;
            window[1] = old_mid;
            window[2] = newer_row[1];
        end
        else
        begin
            window[0] = window[1];
            window[1] = window[2];
            window[2] = (c + 1 < w) ? newer_row[c + 1] : '0;
        end

        if (r >= 2)
        begin
            i = r - 1;
            if (c >= 1 && c <= w - 2)
            begin
                nv = relax(above, value, window[0], window[1], window[2]);
                burst.push_back(plan_write(i, c, nv));
                if (i == 1)
                    burst.push_back(plan_write(0, c, nv));
                if (i == h - 2)
                    burst.push_back(plan_write(h - 1, c, nv));
                if (c == 1)
                    left_edge_val = nv;
                if (c == w - 2)
                    right_edge_val = nv;
            end
            else if (c == w - 1)
            begin
                burst.push_back(plan_write(i, 0, left_edge_val));
                burst.push_back(plan_write(i, w - 1, right_edge_val));
                if (i == 1)
                begin
                    burst.push_back(plan_write(0, 0, left_edge_val));
                    burst.push_back(plan_write(0, w - 1, right_edge_val));
                end
                if (i == h - 2)
                begin
                    burst.push_back(plan_write(h - 1, 0, left_edge_val));
                    burst.push_back(plan_write(h - 1, w - 1, right_edge_val));
                end
            end
        end

        // a three-row grid would need top and bottom corner writes; the bottom corners drop off
        while (burst.size() > MAX_RESULTS)
            void'(burst.pop_back());
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            due_writes.push_back(burst[k]);

        older_row[c] = old_mid;
        newer_row[c] = value;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    always @(posedge clk)
    begin
        cell_write_t want;
        if (!rst_n)
        begin
            width_reg      = GRID_WIDTH_RST;
            height_reg     = GRID_HEIGHT_RST;
            diff_gain      = DIFFUSION_GAIN_RST;
            decay_gain     = DECAY_GAIN_RST;
            for (int k = 0; k < MAX_WIDTH_DEF; k++)
            begin
                older_row[k] = '0;
                newer_row[k] = '0;
            end
            window         = '{default: '0};
            left_edge_val  = '0;
            right_edge_val = '0;
            row_pos        = 0;
            col_pos        = 0;
            due_writes.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GRID_WIDTH:     width_reg  = cfg.data[SIZE_BITS-1:0];
                    REG_GRID_HEIGHT:    height_reg = cfg.data[SIZE_BITS-1:0];
                    REG_DIFFUSION_GAIN: diff_gain  = cfg.data[GAIN_BITS-1:0];
                    REG_DECAY_GAIN:     decay_gain = cfg.data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (cells.valid && cells.ready)
                stencil_update(cells.cell_value, cells.grid_start);
            if (writes.valid && writes.ready)
            begin
                if (due_writes.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected write, expected none, got row %0d col %0d",
                             $time, writes.row_index, writes.column_index,
                             " value %h last %0b", writes.new_value, writes.last_of_run);
                end
                else
                begin
                    want = due_writes.pop_front();
                    checked++;
                    if (writes.row_index !== want.row || writes.column_index !== want.col
                        || writes.new_value !== want.value || writes.last_of_run !== want.last)
                    begin
                        failures++;
                        $display("%0t: write mismatch, expected row %0d col %0d value %h",
                                 $time, want.row, want.col, want.value,
                                 " last %0b, got row %0d col %0d value %h last %0b",
                                 want.last, writes.row_index, writes.column_index,
                                 writes.new_value, writes.last_of_run);
                    end
                end
            end
        end
        awaited = due_writes.size();
    end

endmodule

// ===== verif/reaction_diffusion_stencil_step_tb.sv =====
// Testbench top for the diffusion stencil step: clock, reset, register setup, cell stream
// and write-side backpressure. Depends on rds_pkg, rds_ifs, the block and rds_step_checker.
module reaction_diffusion_stencil_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rds_pkg::*;

    localparam int RANDOM_CELLS     = 100;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 16;

    typedef enum int {FILL_RANDOM, FILL_SMOOTH, FILL_EXTREME, FILL_MIXED} fill_t;

    logic clk = 1'b0;
    logic rst_n;

    rds_cfg_if   cfg_ch ();
    rds_cell_if  cell_ch ();
    rds_write_if write_ch ();

    int failures;
    int awaited;
    int checked;
    bit idling;
    int holds_asked;
    int holds_done;
    int cells_sent;
    int grids_sent;

    reaction_diffusion_stencil_step u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .cells  (cell_ch),
        .writes (write_ch)
    );

    rds_step_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .cells    (cell_ch),
        .writes   (write_ch),
        .failures (failures),
        .awaited  (awaited),
        .checked  (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // write-side backpressure: random low bursts, plus one long hold on request
    initial
    begin
        write_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                write_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                holds_done++;
                write_ch.ready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                write_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                write_ch.ready <= 1'b1;
            end
            else
                write_ch.ready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 9000));
            1:       return 16'($urandom);
            2:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [31:0] pick_value(fill_t fill);
        fill_t f;
        f = (fill == FILL_MIXED) ? fill_t'($urandom_range(0, 2)) : fill;
        case (f)
            FILL_SMOOTH:
                return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    // called on a falling edge; leaves valid high so the next word can follow directly
    task automatic send_cell(input logic [31:0] value, input bit start);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_value <= value;
        cell_ch.grid_start <= start;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        cells_sent++;
        @(negedge clk);
    endtask

    // stop the cell stream and let every predicted write come out
    task automatic settle();
        cell_ch.valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] dg, input logic [15:0] kg);
        logic [CFG_INDEX_BITS-1:0] regs [4];
        logic [CFG_DATA_BITS-1:0]  vals [4];
        settle();
        regs = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_DIFFUSION_GAIN, REG_DECAY_GAIN};
        vals = '{w, h, dg, kg};
        for (int k = 0; k < 4; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[k];
            cfg_ch.data  <= vals[k];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // w and h are the sizes in effect; stop_at cuts the grid short, pause_at drains mid-grid
    task automatic send_grid(input int unsigned w, input int unsigned h, input fill_t fill,
                             input bit start, input int stop_at, input int pause_at);
        int n;
        n = (stop_at >= 0) ? stop_at : int'(w * h);
        for (int k = 0; k < n; k++)
        begin
            if (k == pause_at)
                settle();
            send_cell(pick_value(fill), start && k == 0);
        end
        grids_sent++;
    endtask

    initial
    begin
        logic [31:0] lead_vals[$];
        logic [31:0] corner_vals[$];
        int unsigned w, h;
        int          stop, target;
        logic [15:0] raw_w, raw_h;
        fill_t       fill;

        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        cell_ch.valid       = 1'b0;
        cell_ch.cell_value  = '0;
        cell_ch.grid_start  = 1'b0;
        idling              = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 4 wide grid cut short at row 2 col 3, then shrunk to 3x3 without grid_start:
        // the counters wrap into a fresh grid; extremes drive saturation both ways
        lead_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_8000, 32'h7FFF_FFFF, 32'hFFFF_8000};
        configure(16'd4, 16'd5, 16'hFFFF, 16'hFFFF);
        foreach (lead_vals[k])
            send_cell(lead_vals[k], k == 0);
        configure(16'd2, 16'd0, 16'hFFFF, 16'h0000);
        foreach (corner_vals[k])
            send_cell(corner_vals[k], 1'b0);
        grids_sent += 2;

        target = cells_sent + RANDOM_CELLS;
        for (int g = 0; g < 3 || cells_sent < target; g++)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(3, 8);
            h = $urandom_range(3, 7);
            if (g == 1)
            begin
                w = $urandom_range(6, 8);
                h = $urandom_range(5, 7);
            end
            raw_w = (w == 3 && $urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 2)) : 16'(w);
            raw_h = (h == 3 && $urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 2)) : 16'(h);
            configure(raw_w, raw_h, pick_gain(), pick_gain());
            idling = (g < 3) || ($urandom_range(0, 3) != 0);
            fill   = fill_t'($urandom_range(0, 3));
            // second grid: the write side stalls long enough to back up the cell input
            if (g == 1)
                holds_asked++;
            stop = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, w * h - 1)) : -1;
            send_grid(w, h, fill, 1'b1, stop, (g == 2) ? int'(w * h / 2) : -1);
            if ($urandom_range(0, 2) == 0)
                send_grid(w, h, fill, (stop >= 0) || ($urandom_range(0, 1) == 1), -1, -1);
        end

        // sizes given above range on a grid cut short, then a small grid, at full rate
        configure(16'd2047, 16'd1030, pick_gain(), pick_gain());
        idling = 1'b0;
        send_grid(1024, 1024, FILL_MIXED, 1'b1, 20, -1);
        configure(16'd5, 16'd4, pick_gain(), pick_gain());
        send_grid(5, 4, FILL_MIXED, 1'b1, -1, -1);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("summary: %0d cells in %0d grids, %0d writes checked, %0d mismatches",
                 cells_sent, grids_sent, checked, failures);
        $display("summary: grids 3x3 up to 12 wide, sizes below and above range clamped,",
                 " gains from 0 to 65535, stalls on both sides");
        if (failures == 0 && awaited == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
